// File: hw/rtl/ptpb_pkg.sv
// ----------------------------------------------------------------------------
// ptpb_pkg
// Shared constants and types of the palette to premultiplied BGRA expander.
// ----------------------------------------------------------------------------
package ptpb_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int ENTRY_ADDR_W    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int INDEX_W         = 8;
    localparam int COLOR_W         = 32;
    localparam int CHAN_W          = 8;

    // Reciprocal of 3 in 11 fractional bits; exact floor for sums up to 3 * 255.
    localparam logic [10:0] RECIP3     = 11'd683;
    localparam int          RECIP3_SH  = 11;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef logic [COLOR_W-1:0] word_t;

endpackage

// File: hw/rtl/palette_to_premultiplied_bgra.sv
// ----------------------------------------------------------------------------
// palette_to_premultiplied_bgra: paletted pixel expander with premultiplied alpha.
// Takes one word per cycle while the result register is not stalled.
// Stages: input register, gray average, channel times alpha, then the RAM read register.
// Loads write the palette RAM as they leave the multiply stage; a stalled result freezes all.
// Reset (aresetn low, synchronous) empties the pipe, clears gray mode, unloads every entry.
// ----------------------------------------------------------------------------
module palette_to_premultiplied_bgra (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_entry_index,
    input  logic [31:0] s_color_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_bgra
);

    localparam int AW = ptpb_pkg::ENTRY_ADDR_W;
    localparam int CW = ptpb_pkg::CHAN_W;

    // Truncating divide by 255 for a 16-bit product.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return t[15:8];
    endfunction

    logic gray_mode_reg;
    logic advance;

    // stage 1: registered input word
    logic                         v1_reg;
    ptpb_pkg::op_t                op1_reg;
    logic [ptpb_pkg::INDEX_W-1:0] idx1_reg;
    ptpb_pkg::word_t              col1_reg;

    // stage 2: gray applied
    logic                         v2_reg;
    ptpb_pkg::op_t                op2_reg;
    logic [ptpb_pkg::INDEX_W-1:0] idx2_reg;
    logic [CW-1:0]                r2_reg, g2_reg, b2_reg, a2_reg;
    logic [CW-1:0]                r2_next, g2_next, b2_next;

    // stage 3: channel times alpha
    logic                         v3_reg;
    ptpb_pkg::op_t                op3_reg;
    logic [ptpb_pkg::INDEX_W-1:0] idx3_reg;
    logic [2*CW-1:0]              pr3_reg, pg3_reg, pb3_reg;
    logic [CW-1:0]                a3_reg;

    // RAM stage
    ptpb_pkg::word_t              palette_mem [ptpb_pkg::PALETTE_ENTRIES];
    logic [ptpb_pkg::PALETTE_ENTRIES-1:0] loaded_reg;
    ptpb_pkg::word_t              wr_word;
    logic [AW-1:0]                addr3;
    logic                         in_range3;
    logic                         do_load, do_lookup, do_clear;

    // output register
    logic                         m_valid_reg;
    logic                         hit_reg;
    ptpb_pkg::word_t              rd_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // gray average: (r + g + b) / 3 by reciprocal multiply
    always_comb begin
        logic [9:0]  sum;
        logic [20:0] prod;
        sum  = {2'b00, col1_reg[23:16]} + {2'b00, col1_reg[15:8]} + {2'b00, col1_reg[7:0]};
        prod = {11'd0, sum} * {10'd0, ptpb_pkg::RECIP3};
        if (gray_mode_reg) begin
            r2_next = prod[ptpb_pkg::RECIP3_SH +: CW];
            g2_next = prod[ptpb_pkg::RECIP3_SH +: CW];
            b2_next = prod[ptpb_pkg::RECIP3_SH +: CW];
        end else begin
            r2_next = col1_reg[23:16];
            g2_next = col1_reg[15:8];
            b2_next = col1_reg[7:0];
        end
    end

    assign addr3     = idx3_reg[AW-1:0];
    assign in_range3 = {1'b0, idx3_reg} < 9'(ptpb_pkg::PALETTE_ENTRIES);
    assign do_load   = advance && v3_reg && (op3_reg == ptpb_pkg::OP_LOAD) && in_range3;
    assign do_lookup = v3_reg && (op3_reg == ptpb_pkg::OP_LOOKUP);
    assign do_clear  = advance && v3_reg && (op3_reg == ptpb_pkg::OP_CLEAR);
    assign wr_word   = {a3_reg, div255(pr3_reg), div255(pg3_reg), div255(pb3_reg)};

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_mode_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
            loaded_reg    <= '0;
        end else begin
            if (cfg_we) begin
                gray_mode_reg <= cfg_wdata;
            end
            if (advance) begin
                v1_reg      <= s_valid;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                m_valid_reg <= do_lookup;
            end
            if (do_clear) begin
                loaded_reg <= '0;
            end else if (do_load) begin
                loaded_reg[addr3] <= 1'b1;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge aclk) begin
        if (advance) begin
            op1_reg  <= ptpb_pkg::op_t'(s_operation);
            idx1_reg <= s_entry_index;
            col1_reg <= s_color_word;

            op2_reg  <= op1_reg;
            idx2_reg <= idx1_reg;
            r2_reg   <= r2_next;
            g2_reg   <= g2_next;
            b2_reg   <= b2_next;
            a2_reg   <= col1_reg[31:24];

            op3_reg  <= op2_reg;
            idx3_reg <= idx2_reg;
            pr3_reg  <= {8'd0, r2_reg} * {8'd0, a2_reg};
            pg3_reg  <= {8'd0, g2_reg} * {8'd0, a2_reg};
            pb3_reg  <= {8'd0, b2_reg} * {8'd0, a2_reg};
            a3_reg   <= a2_reg;

            hit_reg  <= in_range3 && loaded_reg[addr3];
        end
    end

    // palette RAM: loads and lookups meet at this one stage, so order is kept
    always_ff @(posedge aclk) begin
        if (do_load) begin
            palette_mem[addr3] <= wr_word;
        end
        if (advance && do_lookup) begin
            rd_reg <= palette_mem[addr3];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_bgra = hit_reg ? rd_reg : '0;

endmodule

// File: hw/rtl/ptpb_checker.sv
// ----------------------------------------------------------------------------
// ptpb_checker
// Port-level checks of the palette expander, bound to the top level.
// ----------------------------------------------------------------------------
module ptpb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_operation,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_pixel_bgra
);

    logic lookup_acc;
    assign lookup_acc = s_valid && s_ready &&
                        (s_operation == ptpb_pkg::OP_LOOKUP);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_bgra))
        else $error("result word changed while stalled");

    // output register empty means the input side is open
    a_ready_free: assert property (@(posedge aclk)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked with no pending result");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an unstalled lookup arrives at the output after the input, gray, multiply and output registers
    a_lookup_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        lookup_acc ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("lookup result missing");

endmodule

bind palette_to_premultiplied_bgra ptpb_checker u_ptpb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_operation  (s_operation),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_pixel_bgra (m_pixel_bgra)
);

// File: bench/palette_to_premultiplied_bgra_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_to_premultiplied_bgra_tb
// Drives load, lookup, clear and reserved-code words into the palette
// expander. Random idling is applied on both sides. The receiver holds off
// once for a long stretch. Every lookup result is compared with a local model
// that keeps the converted palette, the loaded flags and the gray setting.
// ----------------------------------------------------------------------------
module palette_to_premultiplied_bgra_tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         SETTLE_CYC  = 8;
    localparam int         HOLD_CYC    = 80;
    localparam int         PHASE_WORDS = 350;

    class bgra_predictor;
        bit              gray;
        ptpb_pkg::word_t stored_color [ptpb_pkg::PALETTE_ENTRIES];
        bit              loaded [ptpb_pkg::PALETTE_ENTRIES];
        ptpb_pkg::word_t expected_pixels [$];
        int              failures;

        function new();
            gray = 1'b0;
            failures = 0;
            foreach (loaded[i]) begin
                loaded[i] = 1'b0;
                stored_color[i] = '0;
            end
        endfunction

        function ptpb_pkg::word_t premultiplied(ptpb_pkg::word_t straight);
            int unsigned a, r, g, b, avg;
            a = 32'(straight[31:24]);
            r = 32'(straight[23:16]);
            g = 32'(straight[15:8]);
            b = 32'(straight[7:0]);
            if (gray) begin
                avg = (r + g + b) / 3;
                r = avg;
                g = avg;
                b = avg;
            end
            r = r * a / 255;
            g = g * a / 255;
            b = b * a / 255;
            return {8'(a), 8'(r), 8'(g), 8'(b)};
        endfunction

        function void accept_word(logic [1:0] op, logic [7:0] idx, ptpb_pkg::word_t color);
            case (op)
                ptpb_pkg::OP_LOAD: begin
                    if (idx < ptpb_pkg::PALETTE_ENTRIES) begin
                        stored_color[idx] = premultiplied(color);
                        loaded[idx] = 1'b1;
                    end
                end
                ptpb_pkg::OP_LOOKUP: begin
                    if (idx < ptpb_pkg::PALETTE_ENTRIES && loaded[idx])
                        expected_pixels.push_back(stored_color[idx]);
                    else
                        expected_pixels.push_back('0);
                end
                ptpb_pkg::OP_CLEAR: begin
                    foreach (loaded[i]) loaded[i] = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(ptpb_pkg::word_t got);
            ptpb_pkg::word_t want;
            if (expected_pixels.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: pixel_bgra %h arrived with nothing pending", $time, got);
                return;
            end
            want = expected_pixels.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: pixel_bgra expected %h actual %h", $time, want, got);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [7:0]  s_entry_index;
    logic [31:0] s_color_word;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_pixel_bgra;

    bgra_predictor board;
    bit            ever_written [ptpb_pkg::PALETTE_ENTRIES];
    logic [7:0]    last_loaded;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            hold_left;

    palette_to_premultiplied_bgra dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_entry_index (s_entry_index),
        .s_color_word  (s_color_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_bgra  (m_pixel_bgra)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: a pending long hold-off wins over the random stall.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_pixel(m_pixel_bgra);
    end

    task automatic send_word(input logic [1:0] op, input logic [7:0] idx,
                             input ptpb_pkg::word_t color);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_entry_index <= idx;
        s_color_word  <= color;
        do @(posedge aclk); while (!(s_valid && s_ready));
        board.accept_word(op, idx, color);
        if (op == ptpb_pkg::OP_LOAD) begin
            ever_written[idx] = 1'b1;
            last_loaded = idx;
        end
    endtask

    // Drop valid, wait out every pending pixel, then let the load pipe drain.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_gray(input bit g);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        board.gray = g;
    endtask

    task automatic run_random(input int count);
        int              done;
        int              pick;
        logic [1:0]      op;
        logic [7:0]      idx;
        ptpb_pkg::word_t color;
        done = 0;
        while (done < count) begin
            pick  = $urandom_range(99);
            idx   = 8'($urandom_range(255));
            color = $urandom;
            case ($urandom_range(5))
                0: color[31:24] = 8'h00;
                1: color[31:24] = 8'hFF;
                default: ;
            endcase
            if (pick < 2) begin
                op = ptpb_pkg::OP_CLEAR;
            end else if (pick < 5) begin
                op = OP_UNUSED;
            end else if (pick < 35) begin
                op = ptpb_pkg::OP_LOAD;
            end else begin
                op = ptpb_pkg::OP_LOOKUP;
                if ($urandom_range(2) == 0)
                    idx = last_loaded;
                // never read a palette word that was never written
                if (!ever_written[idx])
                    op = ptpb_pkg::OP_LOAD;
            end
            send_word(op, idx, color);
            if (op != OP_UNUSED)
                done++;
        end
    endtask

    initial begin
        board          = new();
        last_loaded    = '0;
        hold_left      = 0;
        send_idle_pct  = 11;
        recv_stall_pct = 73;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        s_valid        = 1'b0;
        s_operation    = ptpb_pkg::OP_LOAD;
        s_entry_index  = '0;
        s_color_word   = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_gray(1'b0);
        send_word(ptpb_pkg::OP_LOAD,   8'd0,   32'hFFFF_FFFF);
        send_word(ptpb_pkg::OP_LOAD,   8'd255, 32'h00FF_FFFF);
        send_word(ptpb_pkg::OP_LOAD,   8'd128, 32'h80FF_8001);
        send_word(ptpb_pkg::OP_LOAD,   8'd1,   32'hFF00_0000);
        send_word(ptpb_pkg::OP_LOAD,   8'd2,   32'h7F12_3456);
        send_word(OP_UNUSED,           8'd0,   32'h0000_0000);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd0,   32'h0000_0000);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd255, 32'hFFFF_FFFF);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd128, 32'h0000_0000);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd1,   32'h0000_0000);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd2,   32'h0000_0000);
        settle();

        // entry 2 keeps its color conversion across the mode change
        write_gray(1'b1);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd2,   32'h0000_0000);
        send_word(ptpb_pkg::OP_LOAD,   8'd3,   32'hFF30_80C0);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd3,   32'h0000_0000);
        send_word(ptpb_pkg::OP_LOAD,   8'd4,   32'hFFFF_FFFE);
        send_word(ptpb_pkg::OP_LOAD,   8'd85,  32'h55FF_0102);
        send_word(ptpb_pkg::OP_LOAD,   8'd170, 32'hAAFF_FFFF);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd4,   32'h0000_0000);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd85,  32'h0000_0000);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd170, 32'h0000_0000);
        send_word(ptpb_pkg::OP_CLEAR,  8'd0,   32'h0000_0000);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd0,   32'h0000_0000);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd3,   32'h0000_0000);
        send_word(ptpb_pkg::OP_LOAD,   8'd3,   32'hC0FF_FF00);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd3,   32'h0000_0000);
        send_word(ptpb_pkg::OP_LOOKUP, 8'd255, 32'h0000_0000);
        settle();

        write_gray(1'b0);
        run_random(PHASE_WORDS);
        settle();

        send_idle_pct  = 73;
        recv_stall_pct = 11;
        write_gray(1'b1);
        run_random(PHASE_WORDS);
        settle();

        // no idling; hold the receiver off so the pipe backs up into s_ready
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYC;
        write_gray(1'b0);
        run_random(PHASE_WORDS);
        settle();

        if (board.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
